@@ sv/mffp_pkg.sv @@
// Package for the maze flood-fill planner: sizes, codes, state type.
// No dependencies.
package mffp_pkg;
   localparam int MazeW = 16;
   localparam int MazeH = 16;
   localparam int NCells = MazeW * MazeH;
   localparam int CellW = $clog2(NCells);
   localparam int RouteLen = 256;
   localparam int RouteAw = $clog2(RouteLen);
   localparam int RposW = RouteAw + 1;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_WALLS  = 2'd1;
   localparam logic [1:0] ACT_DECIDE = 2'd2;

   localparam logic [1:0] MODE_READY  = 2'd0;
   localparam logic [1:0] MODE_SEARCH = 2'd1;
   localparam logic [1:0] MODE_ATTACK = 2'd2;

   localparam logic [1:0] CSR_GOAL_X = 2'd0;
   localparam logic [1:0] CSR_GOAL_Y = 2'd1;
   localparam logic [1:0] CSR_MODE   = 2'd2;

   localparam logic [2:0] MV_FORWARD = 3'd0;
   localparam logic [2:0] MV_STOP    = 3'd4;
   localparam logic [2:0] NO_HEAD    = 3'd4;

   localparam logic [1:0] SIDE_OPEN    = 2'd0;
   localparam logic [1:0] SIDE_UNKNOWN = 2'd2;
   localparam logic [7:0] WALLS_UNKNOWN = 8'hAA;
   localparam logic [7:0] DIST_NONE = 8'd255;
   localparam logic [7:0] DIST_MAX  = 8'd254;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SWEEP,     // walls+map init, or map clear
      ST_D_RD,      // decide: read own cell
      ST_D_WT,
      ST_S_RD,      // scoring: read neighbour d
      ST_S_WT,
      ST_S_EV,
      ST_R_RD,      // replay read
      ST_R_WT,
      ST_F_CLR,     // flood: clear map
      ST_F_POP,
      ST_F_WT,
      ST_F_NB,
      ST_F_NWT,
      ST_F_NEV,
      ST_E_RD,      // route extraction
      ST_E_WT,
      ST_E_NB,
      ST_E_NWT,
      ST_E_NEV,
      ST_RESP
   } state_type;

   // neighbour of cell in direction d; valid=0 when off grid
   function automatic logic [CellW:0] nb_cell(input logic [CellW-1:0] c,
                                               input logic [1:0] d);
      logic [CellW-1:0] x;
      logic [CellW-1:0] y;
      logic ok;
      logic [CellW-1:0] r;
      x = c % CellW'(MazeW);
      y = c / CellW'(MazeW);
      ok = 1'b0;
      r = c;
      case (d)
         2'd0: begin
            ok = (y + 1'b1 < CellW'(MazeH));
            r = c + CellW'(MazeW);
         end
         2'd1: begin
            ok = (x + 1'b1 < CellW'(MazeW));
            r = c + 1'b1;
         end
         2'd2: begin
            ok = (y != '0);
            r = c - CellW'(MazeW);
         end
         default: begin
            ok = (x != '0);
            r = c - 1'b1;
         end
      endcase
      return {ok, r};
   endfunction
endpackage

@@ sv/mffp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mffp_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ sv/maze_flood_fill_planner.sv @@
// Maze flood-fill planner top level: sequencer, stores and shared scorer.
// Depends on mffp_pkg and mffp_ram.
//
//  channel  ports                         handshake
//  request  req_*, start, busy            start & !busy
//  result   rsp_*, rsp_strobe             one cycle, no stall
//  config   csr_valid/ready/index/data    valid & ready
//
// After reset a sweep pass initializes walls and map; busy is high.
// Clear map: a sweep pass with busy high. Wall write: busy stays low. Decide:
// in ready mode or for a cell off the grid, straight to the response; else at most
// one neighbour read per direction on the map and wall RAM ports; the strobe
// follows the last busy cycle. First arrival at the goal clears the map, floods
// it and walks the route. Results cannot stall.
module maze_flood_fill_planner
   import mffp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [3:0] req_cell_x,
   input  logic [3:0] req_cell_y,
   input  logic [1:0] req_heading,
   input  logic [1:0] req_side_north,
   input  logic [1:0] req_side_east,
   input  logic [1:0] req_side_south,
   input  logic [1:0] req_side_west,
   output logic       rsp_strobe,
   output logic [2:0] rsp_move,
   output logic       rsp_straight_cells,
   output logic [2:0] rsp_new_heading,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_data
);
   state_type state_ff, state_in;
   logic [3:0] goal_x_ff, goal_y_ff;
   logic [1:0] mode_ff;
   logic init_ff, init_in;          // sweep also writes walls
   logic [CellW:0] cnt_ff, cnt_in;  // sweep / queue index
   logic [CellW:0] tail_ff, tail_in;
   logic [CellW-1:0] cell_ff, cell_in;
   logic [1:0] head_ff, head_in;
   logic [1:0] dir_ff, dir_in;
   logic [7:0] own_w_ff, own_w_in;
   logic [7:0] dv_ff, dv_in;
   logic [3:0] best_ff, best_in;
   logic [2:0] ret_ff, ret_in;
   logic found_ff, found_in;
   logic [1:0] pick_ff, pick_in;
   logic [1:0] prev_ff, prev_in;
   logic [CellW-1:0] pcell_ff, pcell_in;
   logic [RposW-1:0] rlen_ff, rlen_in, rpos_ff, rpos_in;
   logic rready_ff, rready_in;
   logic spat_ff, spat_in;
   logic respond_ff, respond_in;

   logic w_we, d_we, r_we, q_we;
   logic [CellW-1:0] w_wa, w_ra, d_wa, d_ra, q_wa, q_ra;
   logic [7:0] w_wd, w_rd, d_wd, d_rd;
   logic [RouteAw-1:0] r_wa, r_ra;
   logic [1:0] r_wd, r_rd;
   logic [CellW-1:0] q_wd, q_rd;

   mffp_ram #(.Width(8), .Depth(NCells)) u_walls (
      .clock, .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
      .rd_addr(w_ra), .rd_data(w_rd));
   mffp_ram #(.Width(8), .Depth(NCells)) u_dist (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra), .rd_data(d_rd));
   mffp_ram #(.Width(2), .Depth(RouteLen)) u_route (
      .clock, .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
      .rd_addr(r_ra), .rd_data(r_rd));
   mffp_ram #(.Width(CellW), .Depth(NCells)) u_queue (
      .clock, .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));

   logic goal_in_grid;
   logic [CellW-1:0] goal_cell;
   logic req_inside;
   logic [CellW-1:0] req_cell;
   logic [CellW:0] nb;
   logic [CellW:0] nb0;
   logic [CellW:0] nb_nx;
   logic own_open;
   logic [3:0] score;
   logic [1:0] mv;

   always_comb begin
      goal_in_grid = (32'(goal_x_ff) < MazeW) && (32'(goal_y_ff) < MazeH);
      goal_cell = CellW'(32'(goal_y_ff) * MazeW + 32'(goal_x_ff));
      req_inside = (32'(req_cell_x) < MazeW) && (32'(req_cell_y) < MazeH);
      req_cell = CellW'(32'(req_cell_y) * MazeW + 32'(req_cell_x));
      nb = nb_cell(cell_ff, dir_ff);
      nb0 = nb_cell(cell_ff, 2'd0);
      nb_nx = nb_cell(cell_ff, dir_ff + 2'd1);
      own_open = (own_w_ff[2*dir_ff +: 2] == SIDE_OPEN) && nb[CellW];
      // shared scorer
      score = '0;
      if (spat_ff) begin
         if (d_rd == 8'd0) begin
            score = 4'd8;
         end
      end else begin
         if (w_rd[2*dir_ff +: 2] == SIDE_UNKNOWN) begin
            score = 4'd4;
         end
         if (dir_ff == head_ff) begin
            score = score + 4'd2;
         end else if (dir_ff != head_ff + 2'd2) begin
            score = score + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         init_ff <= 1'b1;
         cnt_ff <= '0;
         goal_x_ff <= 4'd2;
         goal_y_ff <= 4'd2;
         mode_ff <= MODE_READY;
         rlen_ff <= '0;
         rpos_ff <= '0;
         rready_ff <= 1'b0;
         spat_ff <= 1'b0;
         respond_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff <= init_in;
         cnt_ff <= cnt_in;
         rlen_ff <= rlen_in;
         rpos_ff <= rpos_in;
         rready_ff <= rready_in;
         spat_ff <= spat_in;
         respond_ff <= respond_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_GOAL_X: goal_x_ff <= csr_data;
               CSR_GOAL_Y: goal_y_ff <= csr_data;
               CSR_MODE:   mode_ff <= csr_data[1:0];
               default: ;
            endcase
         end
      end
      tail_ff <= tail_in;
      cell_ff <= cell_in;
      head_ff <= head_in;
      dir_ff <= dir_in;
      own_w_ff <= own_w_in;
      dv_ff <= dv_in;
      best_ff <= best_in;
      ret_ff <= ret_in;
      found_ff <= found_in;
      pick_ff <= pick_in;
      prev_ff <= prev_in;
      pcell_ff <= pcell_in;
   end

   assign csr_ready = 1'b1;
   assign busy = (state_ff != ST_IDLE);
   assign mv = ret_ff[1:0] - head_ff;

   always_comb begin
      rsp_strobe = respond_ff;
      rsp_move = (ret_ff == NO_HEAD) ? MV_STOP : {1'b0, mv};
      rsp_straight_cells = (ret_ff != NO_HEAD) && (mv == 2'd0);
      rsp_new_heading = ret_ff;
      if (mode_ff == MODE_READY) begin
         rsp_move = MV_STOP;
         rsp_straight_cells = 1'b0;
         rsp_new_heading = {1'b0, head_ff};
      end
   end

   always_comb begin
      state_in = state_ff;
      init_in = init_ff;
      cnt_in = cnt_ff;
      tail_in = tail_ff;
      cell_in = cell_ff;
      head_in = head_ff;
      dir_in = dir_ff;
      own_w_in = own_w_ff;
      dv_in = dv_ff;
      best_in = best_ff;
      ret_in = ret_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      prev_in = prev_ff;
      pcell_in = pcell_ff;
      rlen_in = rlen_ff;
      rpos_in = rpos_ff;
      rready_in = rready_ff;
      spat_in = spat_ff;
      respond_in = 1'b0;
      w_we = 1'b0;
      w_wa = cell_ff;
      w_wd = WALLS_UNKNOWN;
      w_ra = cell_ff;
      d_we = 1'b0;
      d_wa = cell_ff;
      d_wd = DIST_NONE;
      d_ra = cell_ff;
      r_we = 1'b0;
      r_wa = rlen_ff[RouteAw-1:0];
      r_wd = pick_ff;
      r_ra = rpos_ff[RouteAw-1:0];
      q_we = 1'b0;
      q_wa = tail_ff[CellW-1:0];
      q_wd = nb[CellW-1:0];
      q_ra = cnt_ff[CellW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cell_in = req_cell;
               head_in = req_heading;
               ret_in = NO_HEAD;
               case (req_action)
                  ACT_CLEAR: begin
                     cnt_in = '0;
                     init_in = 1'b0;
                     state_in = ST_SWEEP;
                  end
                  ACT_WALLS: begin
                     w_we = req_inside;
                     w_wa = req_cell;
                     w_wd = {req_side_west, req_side_south, req_side_east, req_side_north};
                  end
                  ACT_DECIDE: begin
                     if (mode_ff == MODE_READY || !req_inside) begin
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_D_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP, ST_F_CLR: begin
            w_we = init_ff;
            w_wa = cnt_ff[CellW-1:0];
            d_we = 1'b1;
            d_wa = cnt_ff[CellW-1:0];
            d_wd = (goal_in_grid && cnt_ff[CellW-1:0] == goal_cell) ? 8'd0 : DIST_NONE;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (CellW+1)'(NCells - 1)) begin
               init_in = 1'b0;
               cnt_in = '0;
               tail_in = (CellW+1)'(1);
               q_we = 1'b1;
               q_wa = '0;
               q_wd = goal_cell;
               if (state_ff == ST_SWEEP) begin
                  state_in = ST_IDLE;
               end else if (goal_in_grid) begin
                  state_in = ST_F_POP;
               end else begin
                  state_in = ST_E_RD;
                  cell_in = '0;
               end
            end
         end
         ST_D_RD: begin
            state_in = ST_D_WT;
         end
         ST_D_WT: begin
            own_w_in = w_rd;
            dir_in = 2'd0;
            best_in = '0;
            if (d_rd == DIST_NONE) begin
               if (mode_ff == MODE_SEARCH) begin
                  spat_in = 1'b0;
               end else if (mode_ff == MODE_ATTACK) begin
                  spat_in = 1'b1;
               end
               state_in = ST_S_RD;
            end else if (d_rd == 8'd0) begin
               if (!rready_ff) begin
                  spat_in = 1'b1;
                  ret_in = {1'b0, head_ff + 2'd2};
                  cnt_in = '0;
                  state_in = ST_F_CLR;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               state_in = ST_R_RD;
            end
         end
         ST_S_RD: begin
            w_ra = nb[CellW-1:0];
            d_ra = nb[CellW-1:0];
            state_in = own_open ? ST_S_WT : ST_S_EV;
         end
         ST_S_WT: begin
            if (dir_ff == 2'd0 || score > best_ff) begin
               ret_in = {1'b0, dir_ff};
               best_in = score;
            end
            state_in = ST_S_EV;
         end
         ST_S_EV: begin
            dir_in = dir_ff + 1'b1;
            if (dir_ff == 2'd3 || best_ff >= 4'd8) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_S_RD;
            end
         end
         ST_R_RD: begin
            state_in = ST_R_WT;
         end
         ST_R_WT: begin
            if (rpos_ff < rlen_ff) begin
               ret_in = {1'b0, r_rd};
            end
            if (rpos_ff < RposW'(RouteLen)) begin
               rpos_in = rpos_ff + 1'b1;
            end
            state_in = ST_RESP;
         end
         // flood: pop queue entry, read its walls and distance
         ST_F_POP: begin
            if (cnt_ff == tail_ff) begin
               cell_in = '0;
               state_in = ST_E_RD;
            end else begin
               state_in = ST_F_WT;
            end
         end
         ST_F_WT: begin
            cell_in = q_rd;
            state_in = ST_F_NB;
            cnt_in = cnt_ff + 1'b1;
            d_ra = q_rd;
            w_ra = q_rd;
         end
         ST_F_NB: begin
            own_w_in = w_rd;
            dv_in = d_rd;
            dir_in = 2'd0;
            state_in = (d_rd >= DIST_MAX) ? ST_F_POP : ST_F_NWT;
            d_ra = nb0[CellW-1:0];
         end
         ST_F_NWT: begin
            // hold the neighbour dir_ff address for the evaluate cycle
            d_ra = nb[CellW-1:0];
            state_in = ST_F_NEV;
         end
         ST_F_NEV: begin
            if (own_open && d_rd == DIST_NONE) begin
               d_we = 1'b1;
               d_wa = nb[CellW-1:0];
               d_wd = dv_ff + 1'b1;
               q_we = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
            dir_in = dir_ff + 1'b1;
            d_ra = nb_nx[CellW-1:0];
            state_in = (dir_ff == 2'd3) ? ST_F_POP : ST_F_NWT;
         end
         // route: cell_ff current, dv_ff distance
         ST_E_RD: begin
            state_in = ST_E_WT;
            if (cell_ff == '0) begin
               rlen_in = '0;
               prev_in = 2'd0;
            end
         end
         ST_E_WT: begin
            own_w_in = w_rd;
            dv_in = d_rd;
            dir_in = 2'd0;
            found_in = 1'b0;
            d_ra = nb0[CellW-1:0];
            if (d_rd == 8'd0 || d_rd == DIST_NONE || rlen_ff == RposW'(RouteLen)) begin
               rpos_in = '0;
               rready_in = 1'b1;
               state_in = ST_RESP;
            end else begin
               state_in = ST_E_NB;
            end
         end
         ST_E_NB: begin
            d_ra = nb[CellW-1:0];
            state_in = ST_E_NEV;
         end
         ST_E_NEV: begin
            if (own_open && d_rd == dv_ff - 1'b1 && (!found_ff || pick_ff != prev_ff)) begin
               pick_in = dir_ff;
               pcell_in = nb[CellW-1:0];
               found_in = 1'b1;
            end
            dir_in = dir_ff + 1'b1;
            d_ra = nb_nx[CellW-1:0];
            if (dir_ff == 2'd3) begin
               state_in = ST_E_NWT;
            end else begin
               state_in = ST_E_NB;
            end
         end
         ST_E_NWT: begin
            if (!found_ff) begin
               rpos_in = '0;
               rready_in = 1'b1;
               state_in = ST_RESP;
            end else begin
               r_we = 1'b1;
               rlen_in = rlen_ff + 1'b1;
               prev_in = pick_ff;
               cell_in = pcell_ff;
               w_ra = pcell_ff;
               d_ra = pcell_ff;
               state_in = ST_E_WT;
            end
         end
         ST_RESP: begin
            respond_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
